[rtl/ppu_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_pkg
// Shared types, constants and color helpers for the palette pixel unpacker.
// ---------------------------------------------------------------------------
package ppu_pkg;

	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);
	localparam int LANES     = 4;

	localparam logic       CMD_PAL_WRITE = 1'b0;
	localparam logic       CMD_PIXELS    = 1'b1;

	localparam logic [2:0] DEPTH_OFF  = 3'd0;
	localparam logic [2:0] DEPTH_2BPP = 3'd1;
	localparam logic [2:0] DEPTH_4BPP = 3'd2;
	localparam logic [2:0] DEPTH_8BPP = 3'd3;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  palette_index;
		logic [15:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [23:0] pixel_rgb;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [15:0]       data;
	} pal_wr_t;

	function automatic logic in_palette(input logic [7:0] idx);
		return {1'b0, idx} < 9'(PAL_DEPTH);
	endfunction

	function automatic logic [23:0] rgb444_expand(input logic [15:0] v);
		return {v[11:8], 4'h0, v[7:4], 4'h0, v[3:0], 4'h0};
	endfunction

	function automatic logic [23:0] rgb565_expand(input logic [15:0] v);
		return {v[15:11], 3'h0, v[10:5], 2'h0, v[4:0], 3'h0};
	endfunction

	// palette index for one lane, low bits of the byte first
	function automatic logic [7:0] lane_index(input logic [2:0] code, input logic [7:0] pbyte,
	                                          input logic [1:0] lane);
		logic [7:0] sh2;
		logic [7:0] sh4;
		sh2 = pbyte >> {lane, 1'b0};
		sh4 = pbyte >> {lane, 2'b00};
		unique case (code)
			DEPTH_2BPP: return {6'b0, sh2[1:0]};
			DEPTH_4BPP: return {4'b0, sh4[3:0]};
			default:    return pbyte;
		endcase
	endfunction

	// pixels produced by one pixel-data item
	function automatic logic [2:0] pixel_count(input logic [2:0] code);
		unique case (code)
			DEPTH_OFF:  return 3'd0;
			DEPTH_2BPP: return 3'd4;
			DEPTH_4BPP: return 3'd2;
			default:    return 3'd1;
		endcase
	endfunction

endpackage

[rtl/ppu_lane.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_lane
// One lookup lane: a private copy of the palette, one registered read gated
// by the shared entry valid bit, RGB444 expansion of the entry read.
// ---------------------------------------------------------------------------
module ppu_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ppu_pkg::pal_wr_t          wr,
	input  logic                      rd_en,
	input  logic [7:0]                rd_index,
	input  logic                      rd_vld,
	output logic [23:0]               pixel
);

	logic [15:0]                 mem [ppu_pkg::PAL_DEPTH];
	logic [15:0]                 rdata_q;
	logic                        hit_q;
	logic [ppu_pkg::PAL_AW-1:0]  rd_addr;

	assign rd_addr = rd_index[ppu_pkg::PAL_AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// entries never written read as zero (their valid bits clear at reset)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			if (rd_en) begin
				hit_q <= ppu_pkg::in_palette(rd_index) && rd_vld;
			end
		end
	end

	assign pixel = ppu_pkg::rgb444_expand(hit_q ? rdata_q : 16'h0000);

endmodule

[rtl/ppu_merge.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_merge
// Collects the lane pixels of one item and sends them out one per cycle
// while out_ready is high, flagging the final one.
// ---------------------------------------------------------------------------
module ppu_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [ppu_pkg::LANES-1:0][23:0]     pix_in,
	input  logic [2:0]                          count_in,
	output logic                                can_load,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ppu_pkg::out_item_t                  out_data
);

	logic [ppu_pkg::LANES-1:0][23:0] pix_q;
	logic [2:0]                      count_q;
	logic [1:0]                      idx_q;
	logic                            valid_q;
	logic                            is_last;

	assign is_last   = ({1'b0, idx_q} + 3'd1) == count_q;
	assign can_load  = !valid_q || (out_ready && is_last);
	assign out_valid = valid_q;
	assign out_data  = '{pixel_rgb: pix_q[idx_q], last: is_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
			count_q <= '0;
		end else if (can_load) begin
			valid_q <= load;
			idx_q   <= '0;
			count_q <= count_in;
		end else if (out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			pix_q <= pix_in;
		end
	end

endmodule

[rtl/palette_pixel_unpacker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_pixel_unpacker
// Expands palette-indexed or 16-bit framebuffer words into RGB888 pixels.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): either a palette write (cmd 0)
// or a pixel-data word (cmd 1). Output channel (out_valid/out_ready/out_data):
// one 24-bit pixel per transfer, last set on the final pixel of an item.
// The depth code lives in bits 14:12 of palette entry 0; tft_mode (cfg_we,
// cfg_wdata) picks RGB444 or RGB565 for 16-bit words.
// Four lanes, each with its own palette copy, look up all indices of a byte
// in the same cycle; the merge stage then sends one pixel per cycle while
// out_ready is high. The first pixel of an item passes the lookup registers
// (valid_s1 and the lane read data) and then the merge stage registers
// before out_valid rises. An item gives 4 pixels at 2 bpp, 2 at 4 bpp, 1 at
// 8 and 16 bpp; palette writes and depth-code-0 items give no pixel.
// Reset clears the palette (per-entry valid bits), tft_mode and all control
// state at once; no clearing pass is needed. When the receiver stalls, one
// item waits in the lookup stage and in_ready drops until the merge stage
// has sent the last pixel of the item it holds.
// ---------------------------------------------------------------------------
module palette_pixel_unpacker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppu_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ppu_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);

	logic                                in_xfer;
	logic                                tft_q;
	logic [2:0]                          code_q;
	logic [ppu_pkg::PAL_DEPTH-1:0]       pal_vld_q;
	logic                                valid_s1;
	logic [2:0]                          code_s1;
	logic [15:0]                         word_s1;
	logic                                can_load;
	logic                                rd_en;
	ppu_pkg::pal_wr_t                    pal_wr;
	logic [ppu_pkg::LANES-1:0][7:0]      lane_idx;
	logic [ppu_pkg::LANES-1:0][23:0]     lane_pix;
	logic [ppu_pkg::LANES-1:0][23:0]     load_pix;

	assign in_ready = !valid_s1 || can_load;
	assign in_xfer  = in_valid && in_ready;
	assign rd_en    = in_xfer && (in_data.cmd == ppu_pkg::CMD_PIXELS);

	assign pal_wr.en   = in_xfer && (in_data.cmd == ppu_pkg::CMD_PAL_WRITE)
	                     && ppu_pkg::in_palette(in_data.palette_index);
	assign pal_wr.addr = in_data.palette_index[ppu_pkg::PAL_AW-1:0];
	assign pal_wr.data = in_data.data_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tft_q     <= 1'b0;
			code_q    <= ppu_pkg::DEPTH_OFF;
			pal_vld_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tft_q <= cfg_wdata;
			end
			// one valid bit per entry, shared by all lane copies
			if (pal_wr.en) begin
				pal_vld_q[pal_wr.addr] <= 1'b1;
			end
			// shadow of entry 0 depth field
			if (pal_wr.en && in_data.palette_index == 8'd0) begin
				code_q <= in_data.data_word[14:12];
			end
			if (in_ready) begin
				valid_s1 <= rd_en && (code_q != ppu_pkg::DEPTH_OFF);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			code_s1 <= code_q;
			word_s1 <= in_data.data_word;
		end
	end

	for (genvar k = 0; k < ppu_pkg::LANES; k++) begin : g_lane
		assign lane_idx[k] = ppu_pkg::lane_index(code_q, in_data.data_word[7:0], 2'(k));

		ppu_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (pal_wr),
			.rd_en    (rd_en),
			.rd_index (lane_idx[k]),
			.rd_vld   (pal_vld_q[lane_idx[k][ppu_pkg::PAL_AW-1:0]]),
			.pixel    (lane_pix[k])
		);
	end

	always_comb begin
		load_pix = lane_pix;
		if (code_s1[2]) begin
			load_pix[0] = tft_q ? ppu_pkg::rgb565_expand(word_s1)
			                    : ppu_pkg::rgb444_expand(word_s1);
		end
	end

	ppu_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.pix_in    (load_pix),
		.count_in  (ppu_pkg::pixel_count(code_s1)),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[rtl/ppu_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_checker
// Port-level checks for the palette pixel unpacker, bound to the top level.
// ---------------------------------------------------------------------------
module ppu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input ppu_pkg::in_item_t   in_data,
	input logic                out_valid,
	input logic                out_ready,
	input ppu_pkg::out_item_t  out_data
);

	// a stalled input transfer holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input changed while stalled");

	// a stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// remaining pixels of an item are already held
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid)
		else $error("item pixels interrupted");

	// backpressure only comes from a full output side
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind palette_pixel_unpacker ppu_checker u_ppu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[tb/sv/palette_pixel_unpacker_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_pixel_unpacker_tb
// Self-checking bench for the palette pixel unpacker. A shadow palette and
// mode bit predict the RGB pixels of every accepted input transfer. Each
// output transfer is compared in order against those pixels. Stimulus is a
// directed pass over depth codes 0 to 4 and 7, then random palette setups
// followed by pixel bursts, under three sender/receiver stall mixes.
// ---------------------------------------------------------------------------
module palette_pixel_unpacker_tb;

	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         DRAIN_CYCLES  = 8;
	localparam logic [2:0] DEPTH_16_LO   = 3'd4;
	localparam logic [2:0] DEPTH_16_HI   = 3'd7;
	localparam logic       MODE_RGB444   = 1'b0;
	localparam logic       MODE_RGB565   = 1'b1;

	class rgb_expansion_checker;
		logic [15:0]         shadow_palette [ppu_pkg::PAL_DEPTH];
		logic                tft_rgb565;
		ppu_pkg::out_item_t  pending_pixels [$];
		int                  mismatches;

		function new();
			foreach (shadow_palette[i]) shadow_palette[i] = 16'h0;
			tft_rgb565 = MODE_RGB444;
			mismatches = 0;
		endfunction

		function logic [23:0] expand444(logic [15:0] v);
			logic [7:0] r, g, b;
			r = 8'((v >> 4) & 16'h00f0);
			g = 8'(v & 16'h00f0);
			b = 8'((v << 4) & 16'h00f0);
			return {r, g, b};
		endfunction

		function logic [23:0] expand565(logic [15:0] v);
			logic [7:0] r, g, b;
			r = 8'((v >> 8) & 16'h00f8);
			g = 8'((v >> 3) & 16'h00fc);
			b = 8'((v << 3) & 16'h00f8);
			return {r, g, b};
		endfunction

		function logic [15:0] entry(logic [7:0] idx);
			if (int'(idx) >= ppu_pkg::PAL_DEPTH) return 16'h0;
			return shadow_palette[idx];
		endfunction

		function void take_item(ppu_pkg::in_item_t it);
			logic [2:0]         code;
			logic [7:0]         pbyte;
			logic [7:0]         idx;
			int                 nbits;
			int                 lanes;
			ppu_pkg::out_item_t px;
			if (it.cmd == ppu_pkg::CMD_PAL_WRITE) begin
				if (int'(it.palette_index) < ppu_pkg::PAL_DEPTH)
					shadow_palette[it.palette_index] = it.data_word;
				return;
			end
			code = shadow_palette[0][14:12];
			if (code == ppu_pkg::DEPTH_OFF) return;
			if (code >= DEPTH_16_LO) begin
				px.pixel_rgb = tft_rgb565 ? expand565(it.data_word) : expand444(it.data_word);
				px.last = 1'b1;
				pending_pixels.push_back(px);
				return;
			end
			nbits = (code == ppu_pkg::DEPTH_2BPP) ? 2 : (code == ppu_pkg::DEPTH_4BPP) ? 4 : 8;
			lanes = 8 / nbits;
			pbyte = it.data_word[7:0];
			// low bits of the byte give the first pixel
			for (int k = 0; k < lanes; k++) begin
				idx = 8'(int'(pbyte) & ((1 << nbits) - 1));
				px.pixel_rgb = expand444(entry(idx));
				px.last = (k == lanes - 1);
				pending_pixels.push_back(px);
				pbyte = pbyte >> nbits;
			end
		endfunction

		function void check_pixel(ppu_pkg::out_item_t got);
			ppu_pkg::out_item_t want;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel: rgb %06h last %0b", got.pixel_rgb, got.last);
				return;
			end
			want = pending_pixels.pop_front();
			if (got.pixel_rgb !== want.pixel_rgb || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pixel mismatch: expected rgb %06h last %0b, got rgb %06h last %0b",
					         want.pixel_rgb, want.last, got.pixel_rgb, got.last);
			end
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	ppu_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ppu_pkg::out_item_t out_data;
	logic               cfg_we;
	logic               cfg_wdata;

	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count = 0;

	rgb_expansion_checker sb;

	palette_pixel_unpacker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// both transfers are sampled with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.take_item(in_data);
			if (out_valid && out_ready) sb.check_pixel(out_data);
		end
	end

	always @(negedge clk) begin
		if (arst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] entry0(logic b15, logic [2:0] code, logic [11:0] rgb);
		return {b15, code, rgb};
	endfunction

	function automatic logic [2:0] pick_code();
		int r;
		r = $urandom_range(15);
		if (r == 0) return ppu_pkg::DEPTH_OFF;
		if (r <= 4) return ppu_pkg::DEPTH_2BPP;
		if (r <= 7) return ppu_pkg::DEPTH_4BPP;
		if (r <= 10) return ppu_pkg::DEPTH_8BPP;
		return 3'($urandom_range(DEPTH_16_LO, DEPTH_16_HI));
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [15:0] word);
		ppu_pkg::in_item_t it;
		it.cmd = cmd;
		it.palette_index = idx;
		it.data_word = word;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// hold off until every pixel is out and the pipeline is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_tft(input logic mode);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		sb.tft_rgb565 = mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// palette setup then a pixel run; sometimes just a stray transfer
	task automatic random_burst(output int n);
		int writes;
		int pixels;
		n = 0;
		if ($urandom_range(99) < 15) begin
			send_item(1'($urandom), 8'($urandom), 16'($urandom));
			n = 1;
			return;
		end
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd0, entry0(1'($urandom), pick_code(), 12'($urandom)));
		writes = $urandom_range(4);
		for (int i = 0; i < writes; i++)
			send_item(ppu_pkg::CMD_PAL_WRITE, 8'($urandom_range(1, 255)), 16'($urandom));
		pixels = $urandom_range(3, 10);
		for (int i = 0; i < pixels; i++)
			send_item(ppu_pkg::CMD_PIXELS, 8'($urandom), 16'($urandom));
		n = 1 + writes + pixels;
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input logic mode_a,
	                         input logic mode_b, input int items);
		int sent;
		int n;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		settle();
		write_tft(mode_a);
		sent = 0;
		while (sent < items / 2) begin
			random_burst(n);
			sent += n;
		end
		settle();
		write_tft(mode_b);
		while (sent < items) begin
			random_burst(n);
			sent += n;
		end
	endtask

	initial begin
		sb = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = 1'b0;
		send_idle_pct = 28;
		recv_idle_pct = 67;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// palette is all zero after reset, so depth is off
		send_item(ppu_pkg::CMD_PIXELS, 8'hff, 16'hffff);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd1, 16'h0fff);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd2, 16'h0f00);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd3, 16'h00f0);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd0, entry0(1'b1, ppu_pkg::DEPTH_2BPP, 12'h123));
		send_item(ppu_pkg::CMD_PIXELS, 8'h00, 16'hff1b);
		send_item(ppu_pkg::CMD_PIXELS, 8'hff, 16'h00e4);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd15, 16'hffff);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd0, entry0(1'b0, ppu_pkg::DEPTH_4BPP, 12'h000));
		send_item(ppu_pkg::CMD_PIXELS, 8'h55, 16'ha5f1);
		send_item(ppu_pkg::CMD_PIXELS, 8'haa, 16'h000f);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd255, 16'h0abc);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd0, entry0(1'b0, ppu_pkg::DEPTH_8BPP, 12'hfed));
		send_item(ppu_pkg::CMD_PIXELS, 8'h00, 16'h00ff);
		send_item(ppu_pkg::CMD_PIXELS, 8'hff, 16'hff00);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd0, entry0(1'b0, DEPTH_16_LO, 12'h000));
		send_item(ppu_pkg::CMD_PIXELS, 8'h00, 16'hffff);
		send_item(ppu_pkg::CMD_PIXELS, 8'hff, 16'h0000);
		send_item(ppu_pkg::CMD_PIXELS, 8'h5a, 16'h1234);
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd0, entry0(1'b1, DEPTH_16_HI, 12'h000));
		send_item(ppu_pkg::CMD_PIXELS, 8'ha5, 16'h8421);
		settle();
		write_tft(MODE_RGB565);
		send_item(ppu_pkg::CMD_PIXELS, 8'h00, 16'hffff);
		send_item(ppu_pkg::CMD_PIXELS, 8'hff, 16'hf81f);
		// bit 15 alone leaves the depth code at zero
		send_item(ppu_pkg::CMD_PAL_WRITE, 8'd0, entry0(1'b1, ppu_pkg::DEPTH_OFF, 12'h000));
		send_item(ppu_pkg::CMD_PIXELS, 8'h33, 16'h5a5a);

		run_phase(28, 67, MODE_RGB444, MODE_RGB565, 100);
		run_phase(67, 28, MODE_RGB565, MODE_RGB444, 100);
		run_phase(0, 0, MODE_RGB444, MODE_RGB565, 100);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
